// File: src/tsr_pkg.sv
// tsr_pkg: shared types and command codes for the stream reassembler.
// No dependencies.
`timescale 1ns / 1ps

package tsr_pkg;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_END  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } opcode_t;

    localparam int IDX_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;

endpackage

// File: src/tsr_ram.sv
// tsr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/tcp_stream_reassembler.sv
// Stream reassembler: one command item at a time under a small sequencer. A read
// runs S_READ, S_RWAIT (skipped when empty) and S_FINISH; a no-op runs S_FINISH;
// a push or end mark not beyond the window runs S_DECODE, S_WINDOW, S_SLOT/S_VCHK
// as needed, S_DRAIN/S_DCHK per held byte drained, then S_ENDCHK and S_FINISH. An
// item is taken when start is high and busy low; results appear for one cycle
// with done and cannot be stalled. A clearing pass after reset zeroes every valid
// bit (busy high). Uses tsr_pkg and tsr_ram.
`timescale 1ns / 1ps

module tcp_stream_reassembler
    import tsr_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [IDX_W-1:0]    stream_index,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                last_of_stream,
    output logic                done,
    output logic [BYTE_W-1:0]   read_byte,
    output logic                read_valid,
    output logic [IDX_W-1:0]    ack_position,
    output logic [COUNT_W-1:0]  unassembled_count,
    output logic [COUNT_W-1:0]  assembled_count,
    output logic                input_ended
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int SUM_W  = SLOT_W + 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPACITY - 1);
    localparam logic [SUM_W-1:0]  CAP_S     = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0]  CAP_C     = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0]  CAP_I     = IDX_W'(CAPACITY);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WINDOW,
        S_SLOT,
        S_VCHK,
        S_DRAIN,
        S_DCHK,
        S_ENDCHK,
        S_READ,
        S_RWAIT,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [BYTE_W-1:0]   data_reg, data_next;
    logic                last_reg, last_next;
    logic [IDX_W-1:0]    d_reg, d_next;
    logic                wrap_reg, wrap_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic [IDX_W-1:0]    ack_reg, ack_next;
    logic [SLOT_W-1:0]   ack_slot_reg, ack_slot_next;
    logic [IDX_W-1:0]    read_reg, read_next;
    logic [SLOT_W-1:0]   read_slot_reg, read_slot_next;
    logic [IDX_W-1:0]    end_reg, end_next;
    logic                end_known_reg, end_known_next;
    logic [CNT_W-1:0]    pend_reg, pend_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic                ended_reg, ended_next;

    logic                done_reg, done_next;
    logic [BYTE_W-1:0]   read_byte_reg, read_byte_next;
    logic                read_valid_reg, read_valid_next;
    logic [IDX_W-1:0]    ack_position_reg, ack_position_next;
    logic [COUNT_W-1:0]  unassembled_count_reg, unassembled_count_next;
    logic [COUNT_W-1:0]  assembled_count_reg, assembled_count_next;
    logic                input_ended_reg, input_ended_next;

    // RAM ports
    logic                dat_we;
    logic [SLOT_W-1:0]   dat_waddr;
    logic [SLOT_W-1:0]   dat_raddr;
    logic [BYTE_W-1:0]   dat_rdata;
    logic                vld_we;
    logic [SLOT_W-1:0]   vld_waddr;
    logic                vld_wdata;
    logic [SLOT_W-1:0]   vld_raddr;
    logic                vld_rdata;

    // datapath helpers
    logic [IDX_W:0]      diff;
    logic [IDX_W-1:0]    free_space;
    logic [SUM_W-1:0]    slot_sum;
    logic [SUM_W-1:0]    slot_mod;
    logic [SLOT_W-1:0]   slot_calc;
    logic [IDX_W-1:0]    ack_inc;
    logic [SLOT_W-1:0]   ack_slot_inc;
    logic [IDX_W-1:0]    read_inc;
    logic [SLOT_W-1:0]   read_slot_inc;
    logic                behind;

    tsr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_data_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (data_reg),
        .raddr (dat_raddr),
        .rdata (dat_rdata)
    );

    tsr_ram #(
        .WIDTH (1),
        .DEPTH (CAPACITY)
    ) u_valid_ram (
        .clk   (clk),
        .we    (vld_we),
        .waddr (vld_waddr),
        .wdata (vld_wdata),
        .raddr (vld_raddr),
        .rdata (vld_rdata)
    );

    // slot tracking follows pos % CAPACITY, including the jump at the 2^32 wrap
    always_comb
    begin
        diff       = {1'b0, idx_reg} - {1'b0, ack_reg};
        free_space = CAP_I - IDX_W'(used_reg);
        behind     = d_reg[IDX_W-1];
        slot_sum   = {1'b0, ack_slot_reg} + {1'b0, d_reg[SLOT_W-1:0]};
        slot_mod   = (slot_sum >= CAP_S) ? (slot_sum - CAP_S) : slot_sum;
        // a wrapped index sits below CAPACITY, so it is its own slot
        slot_calc  = wrap_reg ? idx_reg[SLOT_W-1:0] : slot_mod[SLOT_W-1:0];

        ack_inc      = ack_reg + 1'b1;
        ack_slot_inc = ((ack_inc == '0) || (ack_slot_reg == SLOT_LAST)) ? '0
                       : ack_slot_reg + 1'b1;
        read_inc      = read_reg + 1'b1;
        read_slot_inc = ((read_inc == '0) || (read_slot_reg == SLOT_LAST)) ? '0
                        : read_slot_reg + 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        d_next         = d_reg;
        wrap_next      = wrap_reg;
        slot_next      = slot_reg;
        clr_next       = clr_reg;
        ack_next       = ack_reg;
        ack_slot_next  = ack_slot_reg;
        read_next      = read_reg;
        read_slot_next = read_slot_reg;
        end_next       = end_reg;
        end_known_next = end_known_reg;
        pend_next      = pend_reg;
        used_next      = used_reg;
        ended_next     = ended_reg;

        done_next              = 1'b0;
        read_byte_next         = read_byte_reg;
        read_valid_next        = read_valid_reg;
        ack_position_next      = ack_position_reg;
        unassembled_count_next = unassembled_count_reg;
        assembled_count_next   = assembled_count_reg;
        input_ended_next       = input_ended_reg;

        dat_we    = 1'b0;
        dat_waddr = slot_calc;
        dat_raddr = read_slot_reg;
        vld_we    = 1'b0;
        vld_waddr = slot_calc;
        vld_wdata = 1'b0;
        vld_raddr = ack_slot_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                vld_we    = 1'b1;
                vld_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = opcode_t'(opcode);
                    idx_next        = stream_index;
                    data_next       = data_byte;
                    last_next       = last_of_stream;
                    read_byte_next  = '0;
                    read_valid_next = 1'b0;
                    unique case (opcode_t'(opcode)) inside
                        OP_PUSH, OP_END: state_next = S_DECODE;
                        OP_READ:         state_next = S_READ;
                        default:         state_next = S_FINISH;
                    endcase
                end
            end
            S_DECODE:
            begin
                wrap_next  = diff[IDX_W];
                d_next     = diff[IDX_W-1:0];
                state_next = S_WINDOW;
            end
            S_WINDOW:
            begin
                if (!behind && (d_reg >= free_space))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    if (op_reg == OP_PUSH && last_reg)
                    begin
                        end_next       = idx_reg + 1'b1;
                        end_known_next = 1'b1;
                    end
                    else if (op_reg == OP_END)
                    begin
                        end_next       = idx_reg;
                        end_known_next = 1'b1;
                    end
                    if (behind)
                    begin
                        state_next = S_ENDCHK;
                    end
                    else if (op_reg == OP_PUSH)
                    begin
                        state_next = S_SLOT;
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_SLOT:
            begin
                slot_next = slot_calc;
                vld_raddr = slot_calc;
                if (d_reg == '0)
                begin
                    // in-order byte goes straight to the assembled region
                    dat_we        = 1'b1;
                    vld_we        = 1'b1;
                    ack_next      = ack_inc;
                    ack_slot_next = ack_slot_inc;
                    used_next     = used_reg + 1'b1;
                    state_next    = S_DRAIN;
                end
                else
                begin
                    state_next = S_VCHK;
                end
            end
            S_VCHK:
            begin
                dat_waddr = slot_reg;
                vld_waddr = slot_reg;
                vld_wdata = 1'b1;
                if (!vld_rdata)
                begin
                    dat_we    = 1'b1;
                    vld_we    = 1'b1;
                    pend_next = pend_reg + 1'b1;
                end
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                vld_raddr  = ack_slot_reg;
                state_next = (used_reg < CAP_C) ? S_DCHK : S_ENDCHK;
            end
            S_DCHK:
            begin
                vld_waddr = ack_slot_reg;
                if (vld_rdata)
                begin
                    vld_we        = 1'b1;
                    ack_next      = ack_inc;
                    ack_slot_next = ack_slot_inc;
                    used_next     = used_reg + 1'b1;
                    if (pend_reg != '0)
                    begin
                        pend_next = pend_reg - 1'b1;
                    end
                    state_next = S_DRAIN;
                end
                else
                begin
                    state_next = S_ENDCHK;
                end
            end
            S_ENDCHK:
            begin
                if (end_known_reg && (ack_reg == end_reg))
                begin
                    ended_next = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_READ:
            begin
                dat_raddr  = read_slot_reg;
                state_next = (used_reg != '0) ? S_RWAIT : S_FINISH;
            end
            S_RWAIT:
            begin
                read_byte_next  = dat_rdata;
                read_valid_next = 1'b1;
                read_next       = read_inc;
                read_slot_next  = read_slot_inc;
                used_next       = used_reg - 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                done_next              = 1'b1;
                ack_position_next      = ack_reg;
                unassembled_count_next = COUNT_W'(pend_reg);
                assembled_count_next   = COUNT_W'(used_reg);
                input_ended_next       = ended_reg;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_CLEAR;
            op_reg                <= OP_NOP;
            idx_reg               <= '0;
            data_reg              <= '0;
            last_reg              <= 1'b0;
            d_reg                 <= '0;
            wrap_reg              <= 1'b0;
            slot_reg              <= '0;
            clr_reg               <= '0;
            ack_reg               <= '0;
            ack_slot_reg          <= '0;
            read_reg              <= '0;
            read_slot_reg         <= '0;
            end_reg               <= '0;
            end_known_reg         <= 1'b0;
            pend_reg              <= '0;
            used_reg              <= '0;
            ended_reg             <= 1'b0;
            done_reg              <= 1'b0;
            read_byte_reg         <= '0;
            read_valid_reg        <= 1'b0;
            ack_position_reg      <= '0;
            unassembled_count_reg <= '0;
            assembled_count_reg   <= '0;
            input_ended_reg       <= 1'b0;
        end
        else
        begin
            state_reg             <= state_next;
            op_reg                <= op_next;
            idx_reg               <= idx_next;
            data_reg              <= data_next;
            last_reg              <= last_next;
            d_reg                 <= d_next;
            wrap_reg              <= wrap_next;
            slot_reg              <= slot_next;
            clr_reg               <= clr_next;
            ack_reg               <= ack_next;
            ack_slot_reg          <= ack_slot_next;
            read_reg              <= read_next;
            read_slot_reg         <= read_slot_next;
            end_reg               <= end_next;
            end_known_reg         <= end_known_next;
            pend_reg              <= pend_next;
            used_reg              <= used_next;
            ended_reg             <= ended_next;
            done_reg              <= done_next;
            read_byte_reg         <= read_byte_next;
            read_valid_reg        <= read_valid_next;
            ack_position_reg      <= ack_position_next;
            unassembled_count_reg <= unassembled_count_next;
            assembled_count_reg   <= assembled_count_next;
            input_ended_reg       <= input_ended_next;
        end
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign read_byte         = read_byte_reg;
    assign read_valid        = read_valid_reg;
    assign ack_position      = ack_position_reg;
    assign unassembled_count = unassembled_count_reg;
    assign assembled_count   = assembled_count_reg;
    assign input_ended       = input_ended_reg;

endmodule

// File: bench/tcp_stream_reassembler_tb.sv
// Testbench for tcp_stream_reassembler: directed table, then random out-of-order byte streams.
// Each status item is checked against a reassembly-window predictor or a typed row value.
// Depends on tsr_pkg and the tcp_stream_reassembler RTL.
`timescale 1ns / 1ps

module tcp_stream_reassembler_tb
    import tsr_pkg::*;
;

    localparam int DEPTH     = 64;
    localparam int N_DIR     = 21;
    localparam int N_RAND    = 480;
    localparam int TAIL_WAIT = 200;

    typedef struct packed {
        logic [BYTE_W-1:0]  rbyte;
        logic               rvalid;
        logic [IDX_W-1:0]   ack;
        logic [COUNT_W-1:0] held;
        logic [COUNT_W-1:0] assembled;
        logic               ended;
    } status_t;

    typedef struct packed {
        opcode_t            op;
        logic [IDX_W-1:0]   idx;
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic               typed;
        status_t            want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          opcode;
    logic [IDX_W-1:0]    stream_index;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_of_stream;
    logic                done;
    logic [BYTE_W-1:0]   read_byte;
    logic                read_valid;
    logic [IDX_W-1:0]    ack_position;
    logic [COUNT_W-1:0]  unassembled_count;
    logic [COUNT_W-1:0]  assembled_count;
    logic                input_ended;

    // predictor state
    logic [BYTE_W-1:0]   m_ring [DEPTH];
    logic                m_held [DEPTH];
    logic [IDX_W-1:0]    m_ack;
    logic [IDX_W-1:0]    m_rd;
    logic [IDX_W-1:0]    m_end;
    logic                m_end_seen;
    logic [COUNT_W-1:0]  m_held_cnt;
    logic                m_ended;

    status_t             status_due [$];
    int                  mismatch_count = 0;
    dir_row_t            dir_tab [N_DIR];

    tcp_stream_reassembler #(
        .CAPACITY(DEPTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .stream_index     (stream_index),
        .data_byte        (data_byte),
        .last_of_stream   (last_of_stream),
        .done             (done),
        .read_byte        (read_byte),
        .read_valid       (read_valid),
        .ack_position     (ack_position),
        .unassembled_count(unassembled_count),
        .assembled_count  (assembled_count),
        .input_ended      (input_ended)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one item to the predicted window and returns the status it should produce.
    function automatic status_t advance_stream(opcode_t op, logic [IDX_W-1:0] idx,
                                               logic [BYTE_W-1:0] data, logic last);
        status_t          r;
        logic [IDX_W-1:0] used;
        logic [IDX_W-1:0] room;
        logic [IDX_W-1:0] d;
        logic [IDX_W-1:0] slot;
        logic             behind;
        r = '0;
        case (op) inside
            OP_PUSH, OP_END:
            begin
                used   = m_ack - m_rd;
                room   = (used < DEPTH) ? DEPTH - used : '0;
                d      = idx - m_ack;
                behind = d[IDX_W-1];
                // beyond the window: nothing at all happens
                if (behind || d < room)
                begin
                    if (op == OP_PUSH && last)
                    begin
                        m_end      = idx + 1;
                        m_end_seen = 1'b1;
                    end
                    else if (op == OP_END)
                    begin
                        m_end      = idx;
                        m_end_seen = 1'b1;
                    end
                    if (!behind && op == OP_PUSH)
                    begin
                        slot = idx % DEPTH;
                        if (d == 0)
                        begin
                            m_ring[slot] = data;
                            m_held[slot] = 1'b0;
                            m_ack        = m_ack + 1;
                        end
                        else if (!m_held[slot])
                        begin
                            m_ring[slot] = data;
                            m_held[slot] = 1'b1;
                            m_held_cnt   = m_held_cnt + 1;
                        end
                    end
                    if (!behind)
                    begin
                        while ((m_ack - m_rd) < DEPTH && m_held[m_ack % DEPTH])
                        begin
                            m_held[m_ack % DEPTH] = 1'b0;
                            m_ack = m_ack + 1;
                            if (m_held_cnt > 0)
                                m_held_cnt = m_held_cnt - 1;
                        end
                    end
                    if (m_end_seen && m_ack == m_end)
                        m_ended = 1'b1;
                end
            end
            OP_READ:
            begin
                if (m_ack != m_rd)
                begin
                    r.rbyte  = m_ring[m_rd % DEPTH];
                    r.rvalid = 1'b1;
                    m_rd     = m_rd + 1;
                end
            end
            default: ;
        endcase
        used        = m_ack - m_rd;
        r.ack       = m_ack;
        r.held      = m_held_cnt;
        r.assembled = used[COUNT_W-1:0];
        r.ended     = m_ended;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [IDX_W-1:0] got,
                                   input logic [IDX_W-1:0] want);
        $display("ERROR t=%0t %s: got 0x%0h want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Result side: one status item per done strobe, compared with the oldest expected status.
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && done)
        begin
            if (status_due.size() == 0)
            begin
                report_mismatch("status item with none due", ack_position, '0);
            end
            else
            begin
                want = status_due.pop_front();
                if (read_byte !== want.rbyte)
                    report_mismatch("read_byte", read_byte, want.rbyte);
                if (read_valid !== want.rvalid)
                    report_mismatch("read_valid", read_valid, want.rvalid);
                if (ack_position !== want.ack)
                    report_mismatch("ack_position", ack_position, want.ack);
                if (unassembled_count !== want.held)
                    report_mismatch("unassembled_count", unassembled_count, want.held);
                if (assembled_count !== want.assembled)
                    report_mismatch("assembled_count", assembled_count, want.assembled);
                if (input_ended !== want.ended)
                    report_mismatch("input_ended", input_ended, want.ended);
            end
        end
    end

    // Drives one item and waits until it is taken; start drops only for a random gap.
    task automatic send_item(input opcode_t op, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] data, input logic last,
                             input logic typed, input status_t typed_want);
        int      gap;
        status_t pred;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        opcode         <= op;
        stream_index   <= idx;
        data_byte      <= data;
        last_of_stream <= last;
        do
            @(posedge clk);
        while (busy);
        pred = advance_stream(op, idx, data, last);
        status_due.insert(status_due.size(), typed ? typed_want : pred);
    endtask

    initial
    begin
        logic [IDX_W-1:0] room;
        logic [IDX_W-1:0] idx;
        int               roll;
        int               read_pct;
        opcode_t          op;

        rst_n          <= 1'b0;
        start          <= 1'b0;
        opcode         <= OP_NOP;
        stream_index   <= '0;
        data_byte      <= '0;
        last_of_stream <= 1'b0;

        for (int i = 0; i < DEPTH; i++)
        begin
            m_ring[i] = '0;
            m_held[i] = 1'b0;
        end
        m_ack      = '0;
        m_rd       = '0;
        m_end      = '0;
        m_end_seen = 1'b0;
        m_held_cnt = '0;
        m_ended    = 1'b0;

        //            op       index          data   last typed  rbyte  v  ack    held asm end
        dir_tab[0]  = '{OP_READ, 32'h0,        8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 32'd0, 7'd0, 7'd0, 1'b0}};
        dir_tab[1]  = '{OP_NOP,  32'hFFFFFFFF, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 32'd0, 7'd0, 7'd0, 1'b0}};
        dir_tab[2]  = '{OP_PUSH, 32'h0,        8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 32'd1, 7'd0, 7'd1, 1'b0}};
        // behind ack, last bit set: end mark wraps to index zero
        dir_tab[3]  = '{OP_PUSH, 32'hFFFFFFFF, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 32'd1, 7'd0, 7'd1, 1'b0}};
        // first index past the free space: dropped, end mark ignored
        dir_tab[4]  = '{OP_PUSH, 32'd64,       8'hAA, 1'b1, 1'b1, '{8'h00, 1'b0, 32'd1, 7'd0, 7'd1, 1'b0}};
        dir_tab[5]  = '{OP_PUSH, 32'd63,       8'h11, 1'b0, 1'b1, '{8'h00, 1'b0, 32'd1, 7'd1, 7'd1, 1'b0}};
        dir_tab[6]  = '{OP_PUSH, 32'd63,       8'h22, 1'b0, 1'b0, '0};  // duplicate held byte
        dir_tab[7]  = '{OP_PUSH, 32'd3,        8'h33, 1'b0, 1'b0, '0};
        dir_tab[8]  = '{OP_PUSH, 32'd2,        8'h44, 1'b0, 1'b0, '0};
        dir_tab[9]  = '{OP_PUSH, 32'd1,        8'h00, 1'b0, 1'b0, '0};  // fills gap, drains 2..3
        dir_tab[10] = '{OP_READ, 32'h0,        8'h00, 1'b0, 1'b1, '{8'hFF, 1'b1, 32'd4, 7'd1, 7'd3, 1'b0}};
        dir_tab[11] = '{OP_READ, 32'h12345678, 8'h5A, 1'b1, 1'b0, '0};
        dir_tab[12] = '{OP_READ, 32'h0,        8'h00, 1'b0, 1'b0, '0};
        dir_tab[13] = '{OP_READ, 32'h0,        8'h00, 1'b0, 1'b0, '0};
        dir_tab[14] = '{OP_READ, 32'h0,        8'h00, 1'b0, 1'b0, '0};  // nothing assembled
        dir_tab[15] = '{OP_END,  32'd2,        8'h00, 1'b0, 1'b0, '0};  // mark behind ack
        dir_tab[16] = '{OP_END,  32'h80000004, 8'h00, 1'b0, 1'b0, '0};  // half range: behind
        dir_tab[17] = '{OP_END,  32'h80000003, 8'h00, 1'b1, 1'b0, '0};  // just under: beyond
        dir_tab[18] = '{OP_PUSH, 32'd4,        8'h55, 1'b0, 1'b0, '0};
        dir_tab[19] = '{OP_END,  32'd9,        8'h00, 1'b0, 1'b0, '0};
        dir_tab[20] = '{OP_NOP,  32'h0,        8'h00, 1'b0, 1'b0, '0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_item(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].data, dir_tab[i].last,
                      dir_tab[i].typed, dir_tab[i].want);

        read_pct = 25;
        for (int n = 0; n < N_RAND; n++)
        begin
            // read share changes per block so the window both fills to capacity and empties
            if (n % 40 == 0)
                read_pct = $urandom_range(5, 45);
            room = DEPTH - (m_ack - m_rd);
            roll = $urandom_range(0, 99);
            if (roll < read_pct)
                send_item(OP_READ, $urandom, $urandom, $urandom, 1'b0, '0);
            else if (roll < read_pct + 4)
            begin
                if ($urandom_range(0, 3) == 0)
                    idx = m_ack - $urandom_range(1, 8);
                else
                    idx = m_ack + $urandom_range(0, 8);
                send_item(OP_END, idx, $urandom, $urandom, 1'b0, '0);
            end
            else if (roll < read_pct + 8)
                send_item(OP_NOP, $urandom, $urandom, $urandom, 1'b0, '0);
            else if (roll < read_pct + 14)
                send_item(OP_PUSH, $urandom, $urandom, $urandom, 1'b0, '0);
            else
            begin
                idx = m_ack + $urandom_range(0, room);
                send_item(OP_PUSH, idx, $urandom, ($urandom_range(0, 31) == 0), 1'b0, '0);
            end

            // hold off the sender until the block has reported everything
            if (n % 150 == 149)
            begin
                start <= 1'b0;
                do
                    @(posedge clk);
                while (status_due.size() != 0);
            end
        end

        start <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("ERROR timeout with %0d status items outstanding", status_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
